// ----- src/iplum_pkg.sv -----
`default_nettype none
package iplum_pkg;

    // Beat widths on the two streams
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 80;

    // Bit positions of the result fields inside the output tdata
    localparam int unsigned O_CONSUMED = 0;
    localparam int unsigned O_REPLY0   = 1;
    localparam int unsigned O_REPLY1   = 9;
    localparam int unsigned O_REPLY2   = 17;
    localparam int unsigned O_REPLY3   = 25;
    localparam int unsigned O_MEM_WR   = 33;
    localparam int unsigned O_MEM_ADDR = 34;
    localparam int unsigned O_MEM_DATA = 50;
    localparam int unsigned O_ENTER    = 58;
    localparam int unsigned O_DONE     = 59;
    localparam int unsigned O_ENTRY    = 60;

    // Mailbox protocol bytes
    localparam logic [7:0] K_WAKE  = 8'hff;  // port 1 write that starts an upload
    localparam logic [7:0] K_ACK0  = 8'haa;  // ready reply on port 0
    localparam logic [7:0] K_ACK1  = 8'hbb;  // ready reply on port 1
    localparam logic [7:0] K_START = 8'hcc;  // port 0 write that opens the first block

    // Mailbox port numbers
    localparam logic [1:0] P_CNT  = 2'd0;
    localparam logic [1:0] P_DATA = 2'd1;

endpackage
`default_nettype wire

// ----- src/ipl_upload_mailbox.sv -----
// Upload mailbox receiver: one host port write per input beat (tuser = port
// number, tdata = byte), one result beat per write carrying the reply port
// bytes, a possible audio memory write, and the enter-upload / upload-done
// strobes. The block takes one beat per clock while its output is not stalled;
// each result lands in the output register in the cycle after its write, and
// s_axis_tready is high whenever that register is empty or is being taken in the same cycle.
`default_nettype none
module ipl_upload_mailbox (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // host write: port_value
    input  wire logic [7:0]  s_axis_tdata,
    // port_num
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // consumed, reply_zero, reply_one, reply_two, reply_three, mem_write,
    // mem_addr, mem_data, enter_upload, upload_done, entry_addr, 4 zero bits
    output logic [79:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READY = 2'd1,
        MODE_DATA  = 2'd2
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [7:0]  r_latch [4];
    logic [7:0]  n_latch [4];
    logic [7:0]  r_reply [4];
    logic [7:0]  n_reply [4];
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_echo, n_echo;
    logic        r_first, n_first;
    logic        r_out_valid;
    logic [iplum_pkg::OUT_DATA_W-1:0] r_out_data;

    logic        accept;
    logic [1:0]  port;
    logic [7:0]  val;
    logic [15:0] blk_addr;
    logic        consumed, mem_wr, enter, done;
    logic [15:0] mem_addr, entry;
    logic [7:0]  mem_data;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign port          = s_axis_tuser;
    assign val           = s_axis_tdata;

    // Next state and result for the write on the input
    always_comb begin
        n_mode   = r_mode;
        n_latch  = r_latch;
        n_reply  = r_reply;
        n_addr   = r_addr;
        n_echo   = r_echo;
        n_first  = r_first;
        blk_addr = '0;
        consumed = 1'b1;
        mem_wr   = 1'b0;
        mem_addr = '0;
        mem_data = '0;
        enter    = 1'b0;
        done     = 1'b0;
        entry    = '0;
        if (r_mode == MODE_IDLE) begin
            if (port == iplum_pkg::P_DATA && val == iplum_pkg::K_WAKE) begin
                n_mode     = MODE_READY;
                n_latch[0] = '0;
                n_latch[1] = '0;
                n_latch[2] = '0;
                n_latch[3] = '0;
                n_reply[0] = iplum_pkg::K_ACK0;
                n_reply[1] = iplum_pkg::K_ACK1;
                n_reply[2] = '0;
                n_reply[3] = '0;
                enter      = 1'b1;
            end else begin
                consumed = 1'b0;
            end
        end else begin
            n_latch[port] = val;
            blk_addr      = {n_latch[3], n_latch[2]};
            if (r_mode == MODE_READY) begin
                if (port == iplum_pkg::P_CNT && val == iplum_pkg::K_START) begin
                    n_addr     = blk_addr;
                    n_echo     = val;
                    n_first    = 1'b1;
                    n_mode     = MODE_DATA;
                    n_reply[0] = val;
                end
            end else if (port == iplum_pkg::P_CNT) begin
                // data mode counter write; mode code 3 lands here as well
                n_reply[0] = val;
                n_echo     = val;
                priority if (r_first) begin
                    n_first = 1'b0;
                end else if (val == r_echo + 8'd1) begin
                    mem_wr   = 1'b1;
                    mem_addr = r_addr;
                    mem_data = n_latch[1];
                    n_addr   = r_addr + 16'd1;
                end else if (n_latch[1] != 8'd0) begin
                    n_addr  = blk_addr;
                    n_first = 1'b1;
                end else begin
                    n_mode = MODE_IDLE;
                    done   = 1'b1;
                    entry  = blk_addr;
                end
            end
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_latch     <= '{default: '0};
            r_reply     <= '{default: '0};
            r_addr      <= '0;
            r_echo      <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_latch <= n_latch;
                r_reply <= n_reply;
                r_addr  <= n_addr;
                r_echo  <= n_echo;
                r_first <= n_first;
            end
            if (s_axis_tready) begin
                r_out_valid <= s_axis_tvalid;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {4'd0, entry, done, enter, mem_data, mem_addr, mem_wr,
                           n_reply[3], n_reply[2], n_reply[1], n_reply[0], consumed};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// ----- src/iplum_checker.sv -----
`default_nettype none
module iplum_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic [79:0] m_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready
);

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Memory writes only come from consumed, plain data beats
    a_mem_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[iplum_pkg::O_MEM_WR] |->
            m_axis_tdata[iplum_pkg::O_CONSUMED] &&
            !m_axis_tdata[iplum_pkg::O_DONE] && !m_axis_tdata[iplum_pkg::O_ENTER])
        else $error("memory write on a non-consumed or end beat");

    // Upload start shows the ready handshake on the reply ports
    a_enter_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[iplum_pkg::O_ENTER] |->
            m_axis_tdata[iplum_pkg::O_REPLY0 +: 8] == iplum_pkg::K_ACK0 &&
            m_axis_tdata[iplum_pkg::O_REPLY1 +: 8] == iplum_pkg::K_ACK1)
        else $error("upload start without ready reply");

    // Unused fields stay zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[iplum_pkg::O_MEM_WR] ||
             (m_axis_tdata[iplum_pkg::O_MEM_ADDR +: 16] == 16'd0 &&
              m_axis_tdata[iplum_pkg::O_MEM_DATA +: 8] == 8'd0)) &&
            (m_axis_tdata[iplum_pkg::O_DONE] ||
             m_axis_tdata[iplum_pkg::O_ENTRY +: 16] == 16'd0))
        else $error("idle result field not zero");

endmodule

bind ipl_upload_mailbox iplum_checker u_iplum_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
module tb;

    // Mailbox address ports (block start address, low and high byte)
    localparam logic [1:0] P_ADDR_LO = 2'd2;
    localparam logic [1:0] P_ADDR_HI = 2'd3;

    typedef enum logic [1:0] {
        MB_IDLE  = 2'd0,
        MB_READY = 2'd1,
        MB_DATA  = 2'd2
    } t_mb_mode;

    // One result beat, field by field
    typedef struct packed {
        logic        consumed;
        logic [7:0]  reply0;
        logic [7:0]  reply1;
        logic [7:0]  reply2;
        logic [7:0]  reply3;
        logic        mem_wr;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic        enter;
        logic        done;
        logic [15:0] entry;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;

    ipl_upload_mailbox DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),   // port_value
        .s_axis_tuser  (s_axis_tuser),   // port_num
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // consumed, reply_zero..reply_three, mem_write, mem_addr, mem_data,
        // enter_upload, upload_done, entry_addr, 4 zero bits
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // Mirror of the mailbox state
    t_mb_mode    mb_mode;
    logic [7:0]  mb_latch [4];
    logic [15:0] mb_up_addr;
    logic [7:0]  mb_echo;
    logic        mb_first;
    logic [7:0]  mb_reply [4];

    t_reply      pending_replies [$];
    int          err_cnt;
    int          taken_cnt;
    int          src_idle_pct;
    int          sink_idle_pct;

    logic        out_fire;
    logic [79:0] out_beat;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one host write to the mirror and return the reply it causes
    function automatic t_reply mailbox_step(logic [1:0] port, logic [7:0] val);
        t_reply      r;
        logic [15:0] blk;
        logic [7:0]  nxt;
        r = '0;
        r.consumed = 1'b1;
        if (mb_mode == MB_IDLE) begin
            if (port == iplum_pkg::P_DATA && val == iplum_pkg::K_WAKE) begin
                mb_mode = MB_READY;
                for (int k = 0; k < 4; k++) mb_latch[k] = 8'h00;
                mb_reply[0] = iplum_pkg::K_ACK0;
                mb_reply[1] = iplum_pkg::K_ACK1;
                mb_reply[2] = 8'h00;
                mb_reply[3] = 8'h00;
                r.enter = 1'b1;
            end else begin
                r.consumed = 1'b0;
            end
        end else begin
            mb_latch[port] = val;
            blk = {mb_latch[3], mb_latch[2]};
            nxt = mb_echo + 8'd1;
            if (mb_mode == MB_READY) begin
                if (port == iplum_pkg::P_CNT && val == iplum_pkg::K_START) begin
                    mb_up_addr  = blk;
                    mb_echo     = val;
                    mb_first    = 1'b1;
                    mb_mode     = MB_DATA;
                    mb_reply[0] = val;
                end
            end else if (port == iplum_pkg::P_CNT) begin
                mb_reply[0] = val;
                if (mb_first) begin
                    // handshake counter: nothing stored
                    mb_first = 1'b0;
                    mb_echo  = val;
                end else if (val == nxt) begin
                    r.mem_wr   = 1'b1;
                    r.mem_addr = mb_up_addr;
                    r.mem_data = mb_latch[1];
                    mb_up_addr = mb_up_addr + 16'd1;
                    mb_echo    = val;
                end else if (mb_latch[1] != 8'h00) begin
                    // counter jump with data byte set: next block
                    mb_up_addr = blk;
                    mb_echo    = val;
                    mb_first   = 1'b1;
                end else begin
                    mb_mode = MB_IDLE;
                    r.done  = 1'b1;
                    r.entry = blk;
                end
            end
        end
        r.reply0 = mb_reply[0];
        r.reply1 = mb_reply[1];
        r.reply2 = mb_reply[2];
        r.reply3 = mb_reply[3];
        return r;
    endfunction

    // Drive one host write and wait until it is taken
    task automatic send_write(input logic [1:0] port, input logic [7:0] val);
        logic   rdy;
        t_reply r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tuser  <= port;
        s_axis_tdata  <= val;
        s_axis_tvalid <= 1'b1;
        forever begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
            if (rdy) break;
        end
        r = mailbox_step(port, val);
        pending_replies.push_back(r);
        if (r.consumed) taken_cnt++;
    endtask

    // Hold the sender until every reply is back
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cmp_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    task automatic check_beat(input logic [79:0] d);
        t_reply e;
        if (pending_replies.size() == 0) begin
            $error("reply beat with nothing pending: %h", d);
            err_cnt++;
        end else begin
            e = pending_replies.pop_front();
            cmp_field("consumed", 16'(e.consumed), 16'(d[iplum_pkg::O_CONSUMED]));
            cmp_field("reply_zero", 16'(e.reply0), 16'(d[iplum_pkg::O_REPLY0 +: 8]));
            cmp_field("reply_one", 16'(e.reply1), 16'(d[iplum_pkg::O_REPLY1 +: 8]));
            cmp_field("reply_two", 16'(e.reply2), 16'(d[iplum_pkg::O_REPLY2 +: 8]));
            cmp_field("reply_three", 16'(e.reply3), 16'(d[iplum_pkg::O_REPLY3 +: 8]));
            cmp_field("mem_write", 16'(e.mem_wr), 16'(d[iplum_pkg::O_MEM_WR]));
            cmp_field("mem_addr", e.mem_addr, d[iplum_pkg::O_MEM_ADDR +: 16]);
            cmp_field("mem_data", 16'(e.mem_data), 16'(d[iplum_pkg::O_MEM_DATA +: 8]));
            cmp_field("enter_upload", 16'(e.enter), 16'(d[iplum_pkg::O_ENTER]));
            cmp_field("upload_done", 16'(e.done), 16'(d[iplum_pkg::O_DONE]));
            cmp_field("entry_addr", e.entry, d[iplum_pkg::O_ENTRY +: 16]);
        end
    endtask

    // Sample the output handshake away from the active edge
    always @(negedge i_clk) begin
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        out_beat = m_axis_tdata;
    end

    // Check taken beats and stall the receiver
    always @(posedge i_clk) begin
        if (out_fire) check_beat(out_beat);
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Writes while idle that are not the wake byte on the data port
    task automatic test_idle_writes();
        send_write(iplum_pkg::P_CNT, iplum_pkg::K_WAKE);
        send_write(iplum_pkg::P_DATA, 8'hfe);
        send_write(P_ADDR_LO, 8'h00);
        send_write(P_ADDR_HI, 8'hff);
    endtask

    // Full transfer: address wrap, counter wrap, second block, finish
    task automatic test_upload_sequence();
        send_write(iplum_pkg::P_DATA, iplum_pkg::K_WAKE);
        send_write(P_ADDR_LO, 8'hff);
        send_write(P_ADDR_HI, 8'hff);
        send_write(iplum_pkg::P_DATA, 8'h12);
        send_write(iplum_pkg::P_CNT, 8'h00);              // ready, not the start byte
        send_write(iplum_pkg::P_CNT, iplum_pkg::K_START); // block at ffff
        send_write(iplum_pkg::P_CNT, 8'hfe);              // handshake
        send_write(iplum_pkg::P_DATA, 8'hab);
        send_write(iplum_pkg::P_CNT, 8'hff);              // store at ffff
        send_write(iplum_pkg::P_DATA, 8'h00);
        send_write(iplum_pkg::P_CNT, 8'h00);              // store at 0000, counter wraps
        send_write(P_ADDR_LO, 8'h34);
        send_write(P_ADDR_HI, 8'h12);
        send_write(iplum_pkg::P_DATA, 8'h55);
        send_write(iplum_pkg::P_CNT, 8'h77);              // jump, data nonzero: block at 1234
        send_write(iplum_pkg::P_CNT, 8'h10);              // handshake
        send_write(iplum_pkg::P_DATA, 8'h00);
        send_write(iplum_pkg::P_CNT, 8'h20);              // jump, data zero: finish
    endtask

    // Random sessions steered by the mirrored mode
    task automatic test_random_sessions(input int n_items);
        int         start;
        int unsigned r;
        logic [7:0] jump;
        start = taken_cnt;
        while (taken_cnt - start < n_items) begin
            r    = $urandom_range(99);
            jump = mb_echo + 8'd2 + 8'($urandom_range(253));
            case (mb_mode)
                MB_IDLE: begin
                    if (r < 85) send_write(iplum_pkg::P_DATA, iplum_pkg::K_WAKE);
                    else send_write(2'($urandom_range(3)), 8'($urandom_range(255)));
                end
                MB_READY: begin
                    if (r < 25) send_write(P_ADDR_LO, 8'($urandom_range(255)));
                    else if (r < 50)
                        send_write(P_ADDR_HI, ($urandom_range(3) == 0) ? 8'hff
                                   : 8'($urandom_range(255)));
                    else if (r < 60)
                        send_write(iplum_pkg::P_DATA, 8'($urandom_range(255)));
                    else if (r < 68)
                        send_write(2'($urandom_range(3)), 8'($urandom_range(255)));
                    else send_write(iplum_pkg::P_CNT, iplum_pkg::K_START);
                end
                default: begin
                    if (mb_first) begin
                        if (r < 85) send_write(iplum_pkg::P_CNT, 8'($urandom_range(255)));
                        else send_write(2'($urandom_range(3)), 8'($urandom_range(255)));
                    end else if (r < 40) begin
                        send_write(iplum_pkg::P_DATA, 8'($urandom_range(255)));
                    end else if (r < 82) begin
                        send_write(iplum_pkg::P_CNT, mb_echo + 8'd1);
                    end else if (r < 86) begin
                        send_write(r[0] ? P_ADDR_HI : P_ADDR_LO, 8'($urandom_range(255)));
                    end else if (r < 92) begin
                        send_write(iplum_pkg::P_CNT, jump);
                    end else if (r < 95) begin
                        send_write(2'($urandom_range(3)), 8'($urandom_range(255)));
                    end else begin
                        send_write(iplum_pkg::P_DATA, 8'h00);
                        send_write(iplum_pkg::P_CNT, jump);
                    end
                end
            endcase
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 2'd0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        out_fire      = 1'b0;
        out_beat      = '0;
        err_cnt       = 0;
        taken_cnt     = 0;
        src_idle_pct  = 26;
        sink_idle_pct = 76;
        mb_mode       = MB_IDLE;
        mb_up_addr    = 16'h0000;
        mb_echo       = 8'h00;
        mb_first      = 1'b0;
        for (int k = 0; k < 4; k++) begin
            mb_latch[k] = 8'h00;
            mb_reply[k] = 8'h00;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_writes();
        test_upload_sequence();
        drain_replies();

        test_random_sessions(670);
        drain_replies();
        src_idle_pct  = 76;
        sink_idle_pct = 26;
        test_random_sessions(670);
        drain_replies();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_sessions(670);

        // end of stimulus: let the last replies come back
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (err_cnt == 0 && pending_replies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
